// ===== sv/heading_pid_turn_controller_core_assert.svh =====
// Assertion macros used by the checker file of the turn controller.
`ifndef HEADING_PID_TURN_CONTROLLER_CORE_ASSERT_SVH
`define HEADING_PID_TURN_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPTC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hptc check failed");

// Consequent must hold in the cycle after the antecedent.
`define HPTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hptc check failed");

`endif

// ===== sv/hptc_pkg.sv =====
`default_nettype none

package hptc_pkg;

   // Payload widths
   localparam int HEADING_W = 16;
   localparam int DRIVE_W   = 8;
   localparam int ANGLE_W   = 15;
   localparam int GAIN_W    = 16;
   localparam int ERR_W     = 17;
   localparam int SUM_W     = 32;

   // Config port
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 3;

   localparam int GAIN_FRAC_BITS_DEF = 8;
   localparam int DRIVE_MAX          = 127;

   typedef logic signed [HEADING_W-1:0] heading_type;
   typedef logic signed [DRIVE_W-1:0]   drive_type;

   // Request opcodes
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Turn direction codes
   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_TARGET_ANGLE     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TURN_DIRECTION   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN       = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SETTLE_THRESHOLD = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_ZONE    = 3'd6;

   // Register reset values
   localparam logic [ANGLE_W-1:0] TARGET_ANGLE_RST     = 15'd0;
   localparam logic               TURN_DIRECTION_RST   = DIR_LEFT;
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST        = 16'd26;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST       = 16'd0;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST       = 16'd0;
   localparam logic [ANGLE_W-1:0] SETTLE_THRESHOLD_RST = 15'd2;
   localparam logic [ANGLE_W-1:0] INTEGRAL_ZONE_RST    = 15'd10;

endpackage

`default_nettype wire

// ===== sv/hptc_channels.sv =====
`default_nettype none

interface hptc_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   hptc_pkg::heading_type heading;

   modport source (output valid, output op, output heading, input ready);
   modport sink (input valid, input op, input heading, output ready);
endinterface

interface hptc_rsp_if;
   logic                valid;
   logic                ready;
   hptc_pkg::drive_type left_drive;
   hptc_pkg::drive_type right_drive;
   logic                done_res;

   modport source (output valid, output left_drive, output right_drive, output done_res,
                   input ready);
   modport sink (input valid, input left_drive, input right_drive, input done_res,
                 output ready);
endinterface

`default_nettype wire

// ===== sv/heading_pid_turn_controller_core.sv =====
// Each stage has its own valid and stalls only when full.
// Throughput: one request per cycle unless the result side stalls.
// Stages: request register, error/integral state update, three products, sum and saturate.
// Reset (synchronous, active high): config registers take their reset values, errors and
// integral clear, the settled flag sets and every stage empties.
`default_nettype none

module heading_pid_turn_controller_core #(
   parameter int GAIN_FRAC_BITS = hptc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   hptc_req_if.sink                         req_if,
   hptc_rsp_if.source                       rsp_if,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [hptc_pkg::ADDR_W-1:0] paddr,
   input  wire logic [hptc_pkg::DATA_W-1:0] pwdata,
   output logic      [hptc_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);

   localparam int ERR_W  = hptc_pkg::ERR_W;
   localparam int DIFF_W = ERR_W + 1;
   localparam int SUM_W  = hptc_pkg::SUM_W;
   localparam int GK_W   = hptc_pkg::GAIN_W + 1;        // gain with a zero sign bit
   localparam int PP_W   = GK_W + ERR_W;
   localparam int PD_W   = GK_W + DIFF_W;
   localparam int PI_W   = GK_W + SUM_W;
   localparam int ACC_W  = PI_W + 2;
   localparam int SPD_W  = hptc_pkg::DRIVE_W - 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [hptc_pkg::ANGLE_W-1:0] target_ff;
   logic                         dir_ff;
   logic [hptc_pkg::GAIN_W-1:0]  prop_ff;
   logic [hptc_pkg::GAIN_W-1:0]  deriv_ff;
   logic [hptc_pkg::GAIN_W-1:0]  integ_ff;
   logic [hptc_pkg::ANGLE_W-1:0] settle_ff;
   logic [hptc_pkg::ANGLE_W-1:0] zone_ff;

   logic                             csr_write;
   logic [hptc_pkg::REG_IDX_W-1:0]   csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[hptc_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= hptc_pkg::TARGET_ANGLE_RST;
         dir_ff    <= hptc_pkg::TURN_DIRECTION_RST;
         prop_ff   <= hptc_pkg::PROP_GAIN_RST;
         deriv_ff  <= hptc_pkg::DERIV_GAIN_RST;
         integ_ff  <= hptc_pkg::INTEG_GAIN_RST;
         settle_ff <= hptc_pkg::SETTLE_THRESHOLD_RST;
         zone_ff   <= hptc_pkg::INTEGRAL_ZONE_RST;
      end else if (csr_write) begin
         case (csr_index)
            hptc_pkg::REG_TARGET_ANGLE:     target_ff <= pwdata[hptc_pkg::ANGLE_W-1:0];
            hptc_pkg::REG_TURN_DIRECTION:   dir_ff    <= pwdata[0];
            hptc_pkg::REG_PROP_GAIN:        prop_ff   <= pwdata[hptc_pkg::GAIN_W-1:0];
            hptc_pkg::REG_DERIV_GAIN:       deriv_ff  <= pwdata[hptc_pkg::GAIN_W-1:0];
            hptc_pkg::REG_INTEG_GAIN:       integ_ff  <= pwdata[hptc_pkg::GAIN_W-1:0];
            hptc_pkg::REG_SETTLE_THRESHOLD: settle_ff <= pwdata[hptc_pkg::ANGLE_W-1:0];
            hptc_pkg::REG_INTEGRAL_ZONE:    zone_ff   <= pwdata[hptc_pkg::ANGLE_W-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   // Read back the register at the addressed slot, zero extended.
   always_comb begin
      prdata = '0;
      case (csr_index)
         hptc_pkg::REG_TARGET_ANGLE:     prdata = hptc_pkg::DATA_W'(target_ff);
         hptc_pkg::REG_TURN_DIRECTION:   prdata = hptc_pkg::DATA_W'(dir_ff);
         hptc_pkg::REG_PROP_GAIN:        prdata = hptc_pkg::DATA_W'(prop_ff);
         hptc_pkg::REG_DERIV_GAIN:       prdata = hptc_pkg::DATA_W'(deriv_ff);
         hptc_pkg::REG_INTEG_GAIN:       prdata = hptc_pkg::DATA_W'(integ_ff);
         hptc_pkg::REG_SETTLE_THRESHOLD: prdata = hptc_pkg::DATA_W'(settle_ff);
         hptc_pkg::REG_INTEGRAL_ZONE:    prdata = hptc_pkg::DATA_W'(zone_ff);
         default:                        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage enables: a stage loads when it is empty or the next one loads.
   // This lets a request enter while a finished result waits downstream.
   // ------------------------------------------------------------------
   logic in_valid_ff, st_valid_ff, pr_valid_ff, rsp_valid_ff;
   logic en_in, en_st, en_pr, en_rsp;

   assign en_rsp       = ~rsp_valid_ff | rsp_if.ready;
   assign en_pr        = ~pr_valid_ff | en_rsp;
   assign en_st        = ~st_valid_ff | en_pr;
   assign en_in        = ~in_valid_ff | en_st;
   assign req_if.ready = en_in;

   // ------------------------------------------------------------------
   // Request register
   // ------------------------------------------------------------------
   logic                  in_op_ff;
   hptc_pkg::heading_type in_heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en_in) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in) begin
         in_op_ff      <= req_if.op;
         in_heading_ff <= req_if.heading;
      end
   end

   // ------------------------------------------------------------------
   // Controller state update
   // ------------------------------------------------------------------
   logic signed [ERR_W-1:0] cur_err_ff, cur_err_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic signed [SUM_W-1:0] err_sum_ff, err_sum_in;
   logic                    settled_ff, settled_in;

   function automatic logic [ERR_W-1:0] err_mag(input logic signed [ERR_W-1:0] v);
      return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
   endfunction

   logic signed [ERR_W-1:0] head_ext;
   logic        [ERR_W-1:0] head_mag;
   logic signed [ERR_W-1:0] target_ext;
   logic signed [ERR_W-1:0] new_err;
   logic        [ERR_W-1:0] new_err_mag;
   logic        [ERR_W-1:0] settle_ext;
   logic        [ERR_W-1:0] zone_ext;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;

   always_comb begin
      head_ext    = ERR_W'(in_heading_ff);
      head_mag    = err_mag(head_ext);          // most negative heading gives 32768
      target_ext  = $signed(ERR_W'(target_ff));
      new_err     = target_ext - $signed(head_mag);
      new_err_mag = err_mag(new_err);
      settle_ext  = ERR_W'(settle_ff);
      zone_ext    = ERR_W'(zone_ff);

      // Saturate the integral to the signed 32-bit range.
      sum_wide = (SUM_W+1)'(err_sum_ff) + (SUM_W+1)'(new_err);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end

      cur_err_in  = cur_err_ff;
      prev_err_in = prev_err_ff;
      err_sum_in  = err_sum_ff;
      settled_in  = settled_ff;
      case (in_op_ff)
         hptc_pkg::OP_START: begin
            // Load both errors with the target and empty the integral.
            cur_err_in  = target_ext;
            prev_err_in = target_ext;
            err_sum_in  = '0;
            settled_in  = ERR_W'(target_ff) <= settle_ext;
         end
         hptc_pkg::OP_SAMPLE: begin
            // Ignore samples once settled; the result then reports done.
            if (!settled_ff) begin
               prev_err_in = cur_err_ff;
               cur_err_in  = new_err;
               if (new_err_mag < zone_ext) begin
                  err_sum_in = sum_sat;
               end
               settled_in = (new_err_mag <= settle_ext) && (err_mag(cur_err_ff) <= settle_ext);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         cur_err_ff  <= '0;
         prev_err_ff <= '0;
         err_sum_ff  <= '0;
         settled_ff  <= 1'b1;
      end else if (en_st) begin
         st_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            cur_err_ff  <= cur_err_in;
            prev_err_ff <= prev_err_in;
            err_sum_ff  <= err_sum_in;
            settled_ff  <= settled_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Products of the updated state. The state registers hold the item in
   // the state stage until this stage loads, so the snapshot is exact.
   // ------------------------------------------------------------------
   logic signed [PP_W-1:0]   prod_p_ff, prod_p_in;
   logic signed [PD_W-1:0]   prod_d_ff, prod_d_in;
   logic signed [PI_W-1:0]   prod_i_ff, prod_i_in;
   logic                     pr_settled_ff;
   logic signed [DIFF_W-1:0] err_diff;

   always_comb begin
      err_diff  = DIFF_W'(prev_err_ff) - DIFF_W'(cur_err_ff);
      prod_p_in = $signed({1'b0, prop_ff}) * cur_err_ff;
      prod_d_in = $signed({1'b0, deriv_ff}) * err_diff;
      prod_i_in = $signed({1'b0, integ_ff}) * err_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (en_pr) begin
         pr_valid_ff <= st_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_pr) begin
         prod_p_ff     <= prod_p_in;
         prod_d_ff     <= prod_d_in;
         prod_i_ff     <= prod_i_in;
         pr_settled_ff <= settled_ff;
      end
   end

   // ------------------------------------------------------------------
   // Sum, scale toward zero, clamp to the drive range, apply direction and brake once settled
   // ------------------------------------------------------------------
   logic signed [ACC_W-1:0]            acc;
   logic        [ACC_W-1:0]            acc_mag;
   logic        [ACC_W-1:0]            acc_shift;
   logic        [SPD_W-1:0]            speed;
   hptc_pkg::drive_type                speed_s;
   hptc_pkg::drive_type                left_in, right_in;
   hptc_pkg::drive_type                left_ff, right_ff;
   logic                               done_ff;

   always_comb begin
      acc       = ACC_W'(prod_p_ff) + ACC_W'(prod_d_ff) + ACC_W'(prod_i_ff);
      acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      acc_shift = acc_mag >> GAIN_FRAC_BITS;
      if (|acc_shift[ACC_W-1:SPD_W]) begin
         speed = SPD_W'(hptc_pkg::DRIVE_MAX);
      end else begin
         speed = acc_shift[SPD_W-1:0];
      end
      speed_s = acc[ACC_W-1] ? -$signed({1'b0, speed}) : $signed({1'b0, speed});

      case (dir_ff)
         hptc_pkg::DIR_LEFT:  left_in = -speed_s;
         hptc_pkg::DIR_RIGHT: left_in = speed_s;
         default:             left_in = speed_s;
      endcase
      right_in = -left_in;

      // Brake once settled.
      if (pr_settled_ff) begin
         left_in  = '0;
         right_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_rsp) begin
         rsp_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_rsp) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         done_ff  <= pr_settled_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.left_drive  = left_ff;
   assign rsp_if.right_drive = right_ff;
   assign rsp_if.done_res    = done_ff;

endmodule

`default_nettype wire

// ===== sv/hptc_checker.sv =====
`default_nettype none
`include "heading_pid_turn_controller_core_assert.svh"

module hptc_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire hptc_pkg::drive_type left_drive,
   input wire hptc_pkg::drive_type right_drive,
   input wire logic                done_res
);

   // Pipeline is empty right after reset.
   `HPTC_ASSERT_SAME(a_empty_after_reset, $fell(reset), !rsp_valid)

   // With no result pending, a request is always taken.
   `HPTC_ASSERT_SAME(a_ready_when_out_empty, !rsp_valid, req_ready)

   // Accepted request reaches the result port while the result side stays ready.
   `HPTC_ASSERT_NEXT(a_latency, (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)

   // Stalled result holds.
   `HPTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(left_drive) && $stable(right_drive) && $stable(done_res))

endmodule

bind heading_pid_turn_controller_core hptc_checker u_hptc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .left_drive  (rsp_if.left_drive),
   .right_drive (rsp_if.right_drive),
   .done_res    (rsp_if.done_res)
);

`default_nettype wire
